[sv/three_voice_tone_sequencer_macros.svh]
// assertion macros shared by the sequencer modules
`ifndef THREE_VOICE_TONE_SEQUENCER_MACROS_SVH
`define THREE_VOICE_TONE_SEQUENCER_MACROS_SVH

// same-cycle implication under synchronous reset
`define TVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define TVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tvs_pkg.sv]
// shared types and constants of the tone sequencer
`default_nettype none
package tvs_pkg;

    // input action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // store layout
    localparam logic [15:0] SONG_TABLE = 16'h01E0;
    localparam logic [15:0] NOTE_TABLE = 16'h0200;
    localparam logic [7:0]  END_MARK   = 8'hFF;

    // store read address source
    typedef enum logic [2:0] {
        RD_TAB_LO  = 3'd0,
        RD_TAB_HI  = 3'd1,
        RD_PTR     = 3'd2,
        RD_PTR1    = 3'd3,
        RD_NOTE_LO = 3'd4,
        RD_NOTE_HI = 3'd5
    } t_rdsel;

    // result kind selected for the output register
    typedef enum logic [3:0] {
        EM_MIX_START = 4'd0,
        EM_VOL_ZERO  = 4'd1,
        EM_TONE_LO   = 4'd2,
        EM_TONE_HI   = 4'd3,
        EM_VOL_FLAG  = 4'd4,
        EM_END       = 4'd5,
        EM_MIX_TICK  = 4'd6,
        EM_SWEEP     = 4'd7,
        EM_VOL_OUT   = 4'd8
    } t_emit;

    // controller to datapath
    typedef struct packed {
        logic       take;
        logic       rd_en;
        t_rdsel     rd_sel;
        logic       ptr_lo;
        logic       ptr_hi;
        logic       cap_note;
        logic       cap_dbyte;
        logic       emit;
        t_emit      em_sel;
        logic       last;
        logic [1:0] voice;
        logic       dur_dec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go;
        logic note_end;
        logic dur_zero;
        logic sweep_zero;
    } t_sts;

endpackage
`default_nettype wire

[sv/tvs_if.sv]
// input and result channel interfaces
`default_nettype none
interface tvs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [3:0]  song_number;
    logic [1:0]  sweep_length;
    logic        tone_only;

    modport source (output valid, action, load_address, load_data, song_number,
                    sweep_length, tone_only, input ready);
    modport sink (input valid, action, load_address, load_data, song_number,
                  sweep_length, tone_only, output ready);
endinterface

interface tvs_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] reg_addr;
    logic [7:0] reg_value;
    logic [5:0] repeat_res;
    logic       last;

    modport source (output valid, kind, reg_addr, reg_value, repeat_res, last,
                    input ready);
    modport sink (input valid, kind, reg_addr, reg_value, repeat_res, last,
                  output ready);
endinterface
`default_nettype wire

[sv/tvs_datapath.sv]
// song store, voice state, sweep generator and result register
`default_nettype none
`include "three_voice_tone_sequencer_macros.svh"
module tvs_datapath #(
    parameter int STORE_ADDR_BITS = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tvs_pkg::t_cmd i_cmd,
    output tvs_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_action,
    input  wire logic [11:0]   i_load_address,
    input  wire logic [7:0]    i_load_data,
    input  wire logic [3:0]    i_song_number,
    input  wire logic [1:0]    i_sweep_length,
    input  wire logic          i_tone_only,
    tvs_out_if.source          o_out
);
    localparam int Depth = 1 << STORE_ADDR_BITS;

    logic [7:0]  r_store [Depth];
    logic [7:0]  r_rdata;
    logic [15:0] r_ptr, n_ptr;
    logic [7:0]  r_note, r_dbyte;
    logic [7:0]  r_dur [3];
    logic [7:0]  r_vol [3];
    logic        r_wide;
    logic [3:0]  r_song;
    logic [1:0]  r_sweep;
    logic        r_tone;
    logic [2:0]  r_sw_val;
    logic [5:0]  r_sw_rem;
    logic        r_ovalid, r_kind, r_last;
    logic [3:0]  r_addr;
    logic [7:0]  r_value;
    logic [5:0]  r_rep;

    logic [15:0] rd_addr16, wr_addr16, tab_addr;
    logic        go;
    logic [3:0]  e_addr;
    logic [7:0]  e_value;
    logic [5:0]  e_rep;
    logic        e_kind;
    logic [3:0]  flag_vol;
    logic [7:0]  cur_vol, decay, low_th, high_th;
    logic [5:0]  sweep_len;

    // store write on load transfers, registered read
    assign wr_addr16 = {4'd0, i_load_address};
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_action == tvs_pkg::ACT_LOAD) begin
            r_store[wr_addr16[STORE_ADDR_BITS-1:0]] <= i_load_data;
        end
    end

    assign tab_addr = tvs_pkg::SONG_TABLE + {11'd0, r_song, 1'b0};
    always_comb begin
        unique case (i_cmd.rd_sel)
            tvs_pkg::RD_TAB_LO:  rd_addr16 = tab_addr;
            tvs_pkg::RD_TAB_HI:  rd_addr16 = tab_addr + 16'd1;
            tvs_pkg::RD_PTR:     rd_addr16 = r_ptr;
            tvs_pkg::RD_PTR1:    rd_addr16 = r_ptr + 16'd1;
            tvs_pkg::RD_NOTE_LO: rd_addr16 = tvs_pkg::NOTE_TABLE | {8'd0, r_note};
            tvs_pkg::RD_NOTE_HI: rd_addr16 = tvs_pkg::NOTE_TABLE + 16'd1 + {8'd0, r_note};
            default:             rd_addr16 = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_store[rd_addr16[STORE_ADDR_BITS-1:0]];
        end
    end

    // status back to the controller
    assign go = i_cmd.emit && (!r_ovalid || o_out.ready);
    assign o_sts.go         = go;
    assign o_sts.note_end   = (r_rdata == tvs_pkg::END_MARK);
    assign o_sts.dur_zero   = (r_dur[i_cmd.voice] == 8'd0);
    assign o_sts.sweep_zero = (r_sw_val == 3'd0);

    // per-voice flag volume and decay step
    always_comb begin
        unique case (i_cmd.voice)
            2'd0:    begin flag_vol = 4'hF; low_th = 8'h24; high_th = 8'h30; end
            2'd1:    begin flag_vol = 4'hC; low_th = 8'h18; high_th = 8'h24; end
            default: begin flag_vol = 4'h9; low_th = 8'h0C; high_th = 8'h18; end
        endcase
    end

    assign cur_vol = r_vol[i_cmd.voice];
    always_comb begin
        priority if (cur_vol == 8'd0) begin
            decay = 8'd0;
        end else if (cur_vol < low_th) begin
            decay = 8'd1;
        end else if (i_cmd.voice == 2'd0) begin
            decay = (cur_vol < high_th) ? 8'd2 : 8'd4;
        end else if (!r_wide || cur_vol >= high_th) begin
            decay = 8'd4;
        end else begin
            decay = 8'd2;
        end
    end

    // result field selection
    assign sweep_len = {r_sweep, 4'hF};
    always_comb begin
        e_kind  = 1'b0;
        e_rep   = 6'd1;
        unique case (i_cmd.em_sel)
            tvs_pkg::EM_MIX_START: begin e_addr = 4'd7; e_value = 8'h38; end
            tvs_pkg::EM_VOL_ZERO:  begin e_addr = {2'b10, i_cmd.voice}; e_value = 8'd0; end
            tvs_pkg::EM_TONE_LO:   begin e_addr = {1'b0, i_cmd.voice, 1'b0}; e_value = r_rdata; end
            tvs_pkg::EM_TONE_HI:   begin e_addr = {1'b0, i_cmd.voice, 1'b1}; e_value = r_rdata; end
            tvs_pkg::EM_VOL_FLAG: begin
                e_addr  = {2'b10, i_cmd.voice};
                e_value = r_dbyte[7] ? {4'd0, flag_vol} : 8'd0;
            end
            tvs_pkg::EM_END:       begin e_addr = 4'd0; e_value = 8'd0; e_kind = 1'b1; end
            tvs_pkg::EM_MIX_TICK:  begin e_addr = 4'd7; e_value = r_tone ? 8'h38 : 8'h08; end
            tvs_pkg::EM_SWEEP: begin
                e_addr  = 4'd6;
                e_value = {5'd0, r_sw_val};
                e_rep   = (r_sw_val == 3'd0) ? r_sw_rem : 6'd1;
            end
            tvs_pkg::EM_VOL_OUT:   begin e_addr = {2'b10, i_cmd.voice}; e_value = {2'd0, cur_vol[7:2]}; end
            default:               begin e_addr = 4'd0; e_value = 8'd0; end
        endcase
    end

    // read pointer next value
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_lo) n_ptr = {r_ptr[15:8], r_rdata};
        if (i_cmd.ptr_hi) n_ptr = {r_rdata, r_ptr[7:0]};
        if (go && i_cmd.em_sel == tvs_pkg::EM_VOL_ZERO) n_ptr = r_ptr + 16'd2;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_wide <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_dur[k] <= '0;
                r_vol[k] <= '0;
            end
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.dur_dec) begin
                for (int k = 0; k < 3; k++) r_dur[k] <= r_dur[k] - 8'd1;
            end
            if (go) begin
                unique case (i_cmd.em_sel)
                    tvs_pkg::EM_MIX_START: r_wide <= 1'b1;
                    tvs_pkg::EM_MIX_TICK:  r_wide <= r_tone;
                    tvs_pkg::EM_VOL_ZERO:  r_dur[i_cmd.voice] <= {1'b0, r_rdata[6:0]};
                    tvs_pkg::EM_VOL_FLAG:
                        r_vol[i_cmd.voice] <= r_dbyte[7] ? {2'd0, flag_vol, 2'd0} : 8'd0;
                    tvs_pkg::EM_VOL_OUT:   r_vol[i_cmd.voice] <= cur_vol - decay;
                    default: ;
                endcase
            end
        end
    end

    // captured item fields, record bytes and sweep counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_song  <= i_song_number;
            r_sweep <= i_sweep_length;
            r_tone  <= i_tone_only;
        end
        if (i_cmd.cap_note)  r_note  <= r_rdata;
        if (i_cmd.cap_dbyte) r_dbyte <= r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_val <= '0;
            r_sw_rem <= '0;
        end else if (go && i_cmd.em_sel == tvs_pkg::EM_MIX_TICK) begin
            r_sw_val <= sweep_len[5:3];
            r_sw_rem <= sweep_len;
        end else if (go && i_cmd.em_sel == tvs_pkg::EM_SWEEP && r_sw_val != 3'd0) begin
            r_sw_val <= r_sw_val >> 1;
            r_sw_rem <= r_sw_rem - 6'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (go) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_kind  <= e_kind;
            r_addr  <= e_addr;
            r_value <= e_value;
            r_rep   <= e_rep;
            r_last  <= i_cmd.last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.kind       = r_kind;
    assign o_out.reg_addr   = r_addr;
    assign o_out.reg_value  = r_value;
    assign o_out.repeat_res = r_rep;
    assign o_out.last       = r_last;

    `TVS_ASSERT_NOW(a_sweep_rem, i_clk, i_rst_n, r_sw_val != 3'd0, r_sw_rem > 6'd1, "sweep count ran short")
    `TVS_ASSERT_NOW(a_end_last, i_clk, i_rst_n, r_ovalid && r_kind, r_last && r_addr == 4'd0, "end result malformed")
    `TVS_ASSERT_NEXT(a_go_valid, i_clk, i_rst_n, go, r_ovalid, "result register not loaded")

endmodule
`default_nettype wire

[sv/tvs_controller.sv]
// sequencing state machine of the tone sequencer
`default_nettype none
`include "three_voice_tone_sequencer_macros.svh"
module tvs_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_action,
    output logic               o_ready,
    input  wire tvs_pkg::t_sts i_sts,
    output tvs_pkg::t_cmd      o_cmd
);
    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_SMIX  = 17'h00002,
        ST_STLO  = 17'h00004,
        ST_STHI  = 17'h00008,
        ST_STSET = 17'h00010,
        ST_LNOTE = 17'h00020,
        ST_LCHK  = 17'h00040,
        ST_LVZ   = 17'h00080,
        ST_LTLO  = 17'h00100,
        ST_LTHI  = 17'h00200,
        ST_LVF   = 17'h00400,
        ST_LEND  = 17'h00800,
        ST_TCHK  = 17'h01000,
        ST_TMIX  = 17'h02000,
        ST_TSWP  = 17'h04000,
        ST_TDUR  = 17'h08000,
        ST_TVOL  = 17'h10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_voice, n_voice;
    logic       r_tick, n_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_voice <= '0;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_tick  <= n_tick;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_tick  = r_tick;
        o_cmd   = '0;
        o_cmd.rd_sel = tvs_pkg::RD_PTR;
        o_cmd.em_sel = tvs_pkg::EM_MIX_START;
        o_cmd.voice  = r_voice;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid && i_action == tvs_pkg::ACT_START) begin
                    n_state = ST_SMIX;
                    n_tick  = 1'b0;
                end else if (i_valid && i_action == tvs_pkg::ACT_TICK) begin
                    n_state = ST_TCHK;
                    n_tick  = 1'b1;
                    n_voice = 2'd0;
                end
            end
            ST_SMIX: begin
                o_cmd.emit = 1'b1;
                if (i_sts.go) n_state = ST_STLO;
            end
            ST_STLO: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tvs_pkg::RD_TAB_LO;
                n_state = ST_STHI;
            end
            ST_STHI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = tvs_pkg::RD_TAB_HI;
                o_cmd.ptr_lo = 1'b1;
                n_state = ST_STSET;
            end
            ST_STSET: begin
                o_cmd.ptr_hi = 1'b1;
                n_voice = 2'd0;
                n_state = ST_LNOTE;
            end
            ST_LNOTE: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_LCHK;
            end
            ST_LCHK: begin
                if (i_sts.note_end) begin
                    n_state = ST_LEND;
                end else begin
                    o_cmd.cap_note = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = tvs_pkg::RD_PTR1;
                    n_state = ST_LVZ;
                end
            end
            ST_LVZ: begin
                o_cmd.cap_dbyte = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.em_sel    = tvs_pkg::EM_VOL_ZERO;
                o_cmd.rd_sel    = tvs_pkg::RD_NOTE_LO;
                o_cmd.rd_en     = i_sts.go;
                if (i_sts.go) n_state = ST_LTLO;
            end
            ST_LTLO: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_TONE_LO;
                o_cmd.rd_sel = tvs_pkg::RD_NOTE_HI;
                o_cmd.rd_en  = i_sts.go;
                if (i_sts.go) n_state = ST_LTHI;
            end
            ST_LTHI: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_TONE_HI;
                if (i_sts.go) n_state = ST_LVF;
            end
            ST_LVF: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_VOL_FLAG;
                o_cmd.last   = !r_tick && r_voice == 2'd2;
                if (i_sts.go) begin
                    if (r_voice == 2'd2) begin
                        n_state = r_tick ? ST_TMIX : ST_IDLE;
                    end else begin
                        n_voice = r_voice + 2'd1;
                        n_state = r_tick ? ST_TCHK : ST_LNOTE;
                    end
                end
            end
            ST_LEND: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_END;
                o_cmd.last   = 1'b1;
                if (i_sts.go) n_state = ST_IDLE;
            end
            ST_TCHK: begin
                if (i_sts.dur_zero) begin
                    n_state = ST_LNOTE;
                end else if (r_voice == 2'd2) begin
                    n_state = ST_TMIX;
                end else begin
                    n_voice = r_voice + 2'd1;
                end
            end
            ST_TMIX: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_MIX_TICK;
                if (i_sts.go) n_state = ST_TSWP;
            end
            ST_TSWP: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_SWEEP;
                if (i_sts.go && i_sts.sweep_zero) n_state = ST_TDUR;
            end
            ST_TDUR: begin
                o_cmd.dur_dec = 1'b1;
                n_voice = 2'd0;
                n_state = ST_TVOL;
            end
            ST_TVOL: begin
                o_cmd.emit   = 1'b1;
                o_cmd.em_sel = tvs_pkg::EM_VOL_OUT;
                o_cmd.last   = (r_voice == 2'd2);
                if (i_sts.go) begin
                    if (r_voice == 2'd2) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_voice = r_voice + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `TVS_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !o_cmd.emit && !o_cmd.rd_en, "idle controller active")
    `TVS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.last && i_sts.go, r_state == ST_IDLE, "item did not end on last result")
    `TVS_ASSERT_NOW(a_voice_range, i_clk, i_rst_n, 1'b1, r_voice != 2'd3, "voice index out of range")

endmodule
`default_nettype wire

[sv/three_voice_tone_sequencer.sv]
// Three-voice tone sequencer: one input item at a time. A start writes the mixer, reads the
// two-byte song pointer and loads up to three voices; a tick reloads expired voices, then
// emits the mixer, two to four sweep results and three volumes. A start or a tick reload
// that meets the end mark emits an end result and ends the item. Store bytes are read
// through the single registered read port and every result passes through the output
// register, which the result side can stall.
// The song store has no reset; only bytes written by load items may be read.
`default_nettype none
module three_voice_tone_sequencer #(
    parameter int STORE_ADDR_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tvs_in_if.sink    i_in,
    tvs_out_if.source o_out
);
    tvs_pkg::t_cmd cmd;
    tvs_pkg::t_sts sts;

    tvs_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .o_ready  (i_in.ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    tvs_datapath #(
        .STORE_ADDR_BITS (STORE_ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_in.action),
        .i_load_address (i_in.load_address),
        .i_load_data    (i_in.load_data),
        .i_song_number  (i_in.song_number),
        .i_sweep_length (i_in.sweep_length),
        .i_tone_only    (i_in.tone_only),
        .o_out          (o_out)
    );

endmodule
`default_nettype wire

[bench/tb_tvs_checker.sv]
// checker for the tone sequencer: predicts register writes and compares transfers
`default_nettype none
module tb_tvs_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tvs_in_if.sink    i_in_mon,
    tvs_out_if.sink   i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
        logic [5:0] repeat_res;
        logic       last;
    } t_write;

    // shadow state of the sequencer
    logic [7:0]  song_mem [0:4095];
    logic [15:0] rd_ptr;
    logic [7:0]  dur_left [0:2];
    logic [7:0]  vol_level [0:2];
    logic        wide_mix;
    t_write      expected_writes [$];
    t_write      item_writes [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_writes.size();

    function automatic logic [7:0] mem_rd(input logic [15:0] addr);
        return song_mem[addr[11:0]];
    endfunction

    function automatic void push_write(input logic kind, input logic [3:0] addr,
                                       input logic [7:0] value, input logic [5:0] rep);
        t_write w;
        w.kind = kind;
        w.reg_addr = addr;
        w.reg_value = value;
        w.repeat_res = rep;
        w.last = 1'b0;
        item_writes.push_back(w);
    endfunction

    // load one voice from the stream; zero when the end mark is met
    function automatic bit load_voice(input int v);
        logic [7:0] note, dbyte, vol;
        note = mem_rd(rd_ptr);
        if (note == tvs_pkg::END_MARK) begin
            push_write(1'b1, 4'd0, 8'd0, 6'd1);
            return 0;
        end
        dbyte = mem_rd(rd_ptr + 16'd1);
        rd_ptr = rd_ptr + 16'd2;
        push_write(1'b0, 4'(8 + v), 8'd0, 6'd1);
        dur_left[v] = {1'b0, dbyte[6:0]};
        push_write(1'b0, 4'(2 * v), mem_rd(tvs_pkg::NOTE_TABLE | {8'd0, note}), 6'd1);
        push_write(1'b0, 4'(2 * v + 1),
                   mem_rd(tvs_pkg::NOTE_TABLE + 16'd1 + {8'd0, note}), 6'd1);
        vol = dbyte[7] ? (v == 0 ? 8'h0F : v == 1 ? 8'h0C : 8'h09) : 8'h00;
        push_write(1'b0, 4'(8 + v), vol, 6'd1);
        vol_level[v] = vol << 2;
        return 1;
    endfunction

    function automatic logic [7:0] decay_step(input int v, input logic [7:0] vol);
        logic [7:0] lo, hi;
        if (vol == 8'd0) return 8'd0;
        if (v == 0) return vol < 8'h24 ? 8'd1 : vol < 8'h30 ? 8'd2 : 8'd4;
        lo = v == 1 ? 8'h18 : 8'h0C;
        hi = v == 1 ? 8'h24 : 8'h18;
        if (vol < lo) return 8'd1;
        if (!wide_mix || vol >= hi) return 8'd4;
        return 8'd2;
    endfunction

    function automatic void run_tick(input logic [1:0] sweep, input logic tone);
        int count, run_len;
        logic [7:0] val, run_val;
        for (int v = 0; v < 3; v++)
            if (dur_left[v] == 0 && !load_voice(v)) return;
        wide_mix = tone;
        push_write(1'b0, 4'd7, wide_mix ? 8'h38 : 8'h08, 6'd1);
        count = int'({sweep, 4'hF});
        val = 8'(count >> 3);
        run_val = val;
        run_len = 0;
        for (int i = 0; i < count; i++) begin
            if (val != run_val) begin
                push_write(1'b0, 4'd6, run_val, 6'(run_len));
                run_val = val;
                run_len = 0;
            end
            run_len++;
            val = val >> 1;
        end
        push_write(1'b0, 4'd6, run_val, 6'(run_len));
        for (int v = 0; v < 3; v++) dur_left[v] = dur_left[v] - 8'd1;
        for (int v = 0; v < 3; v++) begin
            push_write(1'b0, 4'(8 + v), vol_level[v] >> 2, 6'd1);
            vol_level[v] = vol_level[v] - decay_step(v, vol_level[v]);
        end
    endfunction

    // work out the writes caused by one accepted input item
    function automatic void predict_item(input logic [1:0] act, input logic [11:0] la,
                                         input logic [7:0] ld, input logic [3:0] song,
                                         input logic [1:0] sweep, input logic tone);
        logic [15:0] entry;
        item_writes.delete();
        if (act == tvs_pkg::ACT_LOAD) begin
            song_mem[la] = ld;
        end else if (act == tvs_pkg::ACT_START) begin
            push_write(1'b0, 4'd7, 8'h38, 6'd1);
            wide_mix = 1'b1;
            entry = tvs_pkg::SONG_TABLE + {11'd0, song, 1'b0};
            rd_ptr = {mem_rd(entry + 16'd1), mem_rd(entry)};
            for (int v = 0; v < 3; v++)
                if (!load_voice(v)) break;
        end else if (act == tvs_pkg::ACT_TICK) begin
            run_tick(sweep, tone);
        end
        if (item_writes.size() > 0) item_writes[item_writes.size() - 1].last = 1'b1;
        foreach (item_writes[i]) expected_writes.push_back(item_writes[i]);
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        t_write got, want;
        if (!i_rst_n) begin
            rd_ptr = 16'd0;
            for (int v = 0; v < 3; v++) begin
                dur_left[v] = 8'd0;
                vol_level[v] = 8'd0;
            end
            wide_mix = 1'b1;
            expected_writes.delete();
            fail_count = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.kind, i_out_mon.reg_addr, i_out_mon.reg_value,
                       i_out_mon.repeat_res, i_out_mon.last};
                if (expected_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %h", got);
                end else begin
                    want = expected_writes.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: kind %0d/%0d addr %0d/%0d val %h/%h",
                                      " rep %0d/%0d last %0d/%0d"},
                                     want.kind, got.kind, want.reg_addr, got.reg_addr,
                                     want.reg_value, got.reg_value, want.repeat_res,
                                     got.repeat_res, want.last, got.last);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_item(i_in_mon.action, i_in_mon.load_address, i_in_mon.load_data,
                             i_in_mon.song_number, i_in_mon.sweep_length,
                             i_in_mon.tone_only);
        end
    end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// top of the tone sequencer testbench: stimulus, clock, reset and verdict
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_COUNT  = 470;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   sent = 0;
    int   fail_count, pending;
    bit   idle_on = 1'b1;
    bit   song_ok [0:15];
    logic [11:0] song_base [0:15];

    tvs_in_if  in_ch ();
    tvs_out_if out_ch ();

    three_voice_tone_sequencer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    tb_tvs_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch.sink),
        .i_out_mon   (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #10 i_clk = ~i_clk;

    // result side stalls at random while idle_on is set
    always @(posedge i_clk) begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 18);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one input transfer, with valid dropped for a random gap in front while idle_on is set
    task automatic send_item(input logic [1:0] act, input logic [11:0] la,
                             input logic [7:0] ld, input logic [3:0] song,
                             input logic [1:0] sweep, input logic tone);
        if (idle_on && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while (idle_on && $urandom_range(99) < 18);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.load_address <= la;
        in_ch.load_data <= ld;
        in_ch.song_number <= song;
        in_ch.sweep_length <= sweep;
        in_ch.tone_only <= tone;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic load_byte(input logic [11:0] addr, input logic [7:0] data);
        send_item(tvs_pkg::ACT_LOAD, addr, data, 4'($urandom), 2'($urandom),
                  1'($urandom));
    endtask

    // write a song: pointer table entry, then records ending with the end mark
    task automatic write_song(input int song, input logic [11:0] base, input int records,
                              input bit long_dur);
        logic [7:0] dbyte;
        load_byte(12'h1E0 + 12'(2 * song), base[7:0]);
        load_byte(12'h1E1 + 12'(2 * song), {4'd0, base[11:8]});
        for (int r = 0; r < records; r++) begin
            load_byte(base + 12'(2 * r), 8'($urandom_range(31)));
            dbyte = long_dur ? 8'($urandom) : {1'($urandom), 7'($urandom_range(3))};
            load_byte(base + 12'(2 * r + 1), dbyte);
        end
        load_byte(base + 12'(2 * records), tvs_pkg::END_MARK);
        song_ok[song] = 1'b1;
    endtask

    task automatic tick_item();
        send_item(tvs_pkg::ACT_TICK, 12'($urandom), 8'($urandom), 4'($urandom),
                  2'($urandom), 1'($urandom));
    endtask

    initial begin
        int song;
        in_ch.valid = 1'b0;
        in_ch.action = tvs_pkg::ACT_LOAD;
        in_ch.load_address = '0;
        in_ch.load_data = '0;
        in_ch.song_number = '0;
        in_ch.sweep_length = '0;
        in_ch.tone_only = 1'b0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the note table entries that the note bytes can reach
        idle_on = 1'b0;
        for (int a = 12'h200; a < 12'h221; a++) load_byte(12'(a), 8'($urandom));
        for (int s = 0; s < 16; s++) song_base[s] = 12'h400 + 12'(s * 12'h0A0);
        // directed: extreme store addresses, an immediate stream end, start, ticks and a no-action item
        load_byte(12'hFFF, 8'hFF);
        load_byte(12'h000, 8'h00);
        write_song(0, song_base[0], 0, 1'b0);
        send_item(tvs_pkg::ACT_START, 12'd0, 8'd0, 4'd0, 2'd0, 1'b0);
        write_song(15, song_base[15], 20, 1'b0);
        send_item(tvs_pkg::ACT_START, 12'hFFF, 8'hFF, 4'd15, 2'd3, 1'b1);
        for (int i = 0; i < 6; i++)
            send_item(tvs_pkg::ACT_TICK, 12'd0, 8'd0, 4'd0, 2'(i), 1'(i));
        send_item(tvs_pkg::ACT_NONE, 12'hFFF, 8'hFF, 4'hF, 2'd3, 1'b1);
        idle_on = 1'b1;

        // random: mostly started songs with ticks, song rewrites and some no-action items
        while (sent < ITEM_COUNT) begin
            song = $urandom_range(15);
            if (!song_ok[song] || $urandom_range(3) == 0)
                write_song(song, song_base[song], $urandom_range(1, 12),
                           $urandom_range(3) == 0);
            send_item(tvs_pkg::ACT_START, 12'($urandom), 8'($urandom), 4'(song),
                      2'($urandom), 1'($urandom));
            for (int t = $urandom_range(2, 25); t > 0; t--) tick_item();
            if ($urandom_range(9) == 0)
                send_item(tvs_pkg::ACT_NONE, 12'($urandom), 8'($urandom), 4'($urandom),
                          2'($urandom), 1'($urandom));
            if (sent > 200 && sent < 260) idle_on = 1'b0;
            else idle_on = 1'b1;
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
